// File: hdl/ndsk_pkg.sv
// ndsk_pkg: shared types and constants for the newest-dates sorted keeper
// depends on nothing; imported by every ndsk module
`timescale 1ns / 1ps
`default_nettype none

package ndsk_pkg;

  // key and name format
  localparam int unsigned KEY_W = 27;
  localparam logic [3:0] NAME_LEN = 4'd14;
  localparam logic [3:0] POS_MAX = 4'd15;
  localparam logic [3:0] DASH_POS_A = 4'd4;
  localparam logic [3:0] DASH_POS_B = 4'd7;
  localparam logic [3:0] TAIL_POS = 4'd10;
  localparam logic [7:0] CHR_DASH = 8'h2D;
  localparam logic [7:0] CHR_ZERO = 8'h30;
  localparam logic [7:0] CHR_NINE = 8'h39;

  // max_keep after reset
  localparam logic [6:0] MAX_KEEP_RST = 7'd60;

  // request codes
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_NAME = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // result kinds
  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // verdict codes
  localparam logic [1:0] VERD_INSERTED = 2'd0;
  localparam logic [1:0] VERD_MALFORMED = 2'd1;
  localparam logic [1:0] VERD_DROPPED = 2'd2;

  // per-cycle operation of the cell row
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SHIFT,
    OP_INSERT
  } cell_op_t;

  // control handed from the sequencer to the cell row
  typedef struct packed {
    cell_op_t op;
    logic [KEY_W-1:0] key;
  } chain_ctl_t;

  // the ".csv" tail, by offset from the tail start
  function automatic logic [7:0] tail_byte(input logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0: b = 8'h2E;
      2'd1: b = 8'h63;
      2'd2: b = 8'h73;
      2'd3: b = 8'h76;
      default: b = 8'h2E;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: hdl/ndsk_name_parser.sv
// ndsk_name_parser: byte-wise check of a DDDD-DD-DD.csv name and key packing
// depends on ndsk_pkg
`timescale 1ns / 1ps
`default_nettype none

module ndsk_name_parser
  import ndsk_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             clear,
  input  wire logic             byte_en,
  input  wire logic [7:0]       name_byte,
  input  wire logic             last_byte,
  output logic                  fin_ok,
  output logic [KEY_W-1:0]      fin_key
);

  logic [3:0]       pos_r, pos_nxt, pos_b;
  logic             ok_r, ok_nxt, ok_b;
  logic [KEY_W-1:0] acc_r, acc_nxt, acc_b;
  logic [1:0]       tail_off;

  // offset into the tail, valid for positions 10 to 13
  assign tail_off = pos_r[1:0] - TAIL_POS[1:0];

  // check the incoming byte at its position and fold in digits
  always_comb begin
    ok_b = ok_r;
    acc_b = acc_r;
    if (pos_r >= NAME_LEN) begin
      ok_b = 1'b0;
    end else if (pos_r == DASH_POS_A || pos_r == DASH_POS_B) begin
      if (name_byte != CHR_DASH) ok_b = 1'b0;
    end else if (pos_r >= TAIL_POS) begin
      if (name_byte != tail_byte(tail_off)) ok_b = 1'b0;
    end else if (name_byte >= CHR_ZERO && name_byte <= CHR_NINE) begin
      acc_b = (acc_r << 3) + (acc_r << 1) + KEY_W'(name_byte - CHR_ZERO);
    end else begin
      ok_b = 1'b0;
    end
    pos_b = (pos_r == POS_MAX) ? POS_MAX : pos_r + 4'd1;
  end

  assign fin_ok = ok_b && (pos_b == NAME_LEN);
  assign fin_key = acc_b;

  // parser returns to its start state on clear or at the end of a name
  always_comb begin
    pos_nxt = pos_r;
    ok_nxt = ok_r;
    acc_nxt = acc_r;
    if (clear || (byte_en && last_byte)) begin
      pos_nxt = '0;
      ok_nxt = 1'b1;
      acc_nxt = '0;
    end else if (byte_en) begin
      pos_nxt = pos_b;
      ok_nxt = ok_b;
      acc_nxt = acc_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ok_r <= 1'b1;
      acc_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      ok_r <= ok_nxt;
      acc_r <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/ndsk_cell.sv
// ndsk_cell: one slot of the sorted row; holds a key, shifts or inserts
// depends on ndsk_pkg
`timescale 1ns / 1ps
`default_nettype none

module ndsk_cell
  import ndsk_pkg::*;
(
  input  wire logic             clk,
  input  wire chain_ctl_t       ctl,
  input  wire logic             slot_used,
  input  wire logic             at_count,
  input  wire logic [KEY_W-1:0] prev_key,
  input  wire logic             prev_gt,
  input  wire logic [KEY_W-1:0] next_key,
  output logic [KEY_W-1:0]      key_o,
  output logic                  gt_o
);

  logic [KEY_W-1:0] key_r, key_nxt;

  // this slot holds a key newer than the one being placed
  assign gt_o = slot_used && (key_r > ctl.key);
  assign key_o = key_r;

  // shift toward the oldest end, or open a gap and drop the new key in
  always_comb begin
    key_nxt = key_r;
    case (ctl.op)
      OP_SHIFT: key_nxt = next_key;
      OP_INSERT: begin
        if (prev_gt) begin
          key_nxt = prev_key;
        end else if (gt_o || at_count) begin
          key_nxt = ctl.key;
        end
      end
      default: key_nxt = key_r;
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

`default_nettype wire

// File: hdl/ndsk_chain.sv
// ndsk_chain: row of key cells kept in ascending order, with slot read mux
// depends on ndsk_pkg and ndsk_cell
`timescale 1ns / 1ps
`default_nettype none

module ndsk_chain
  import ndsk_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                                  clk,
  input  wire chain_ctl_t                            ctl,
  input  wire logic [$clog2(CAPACITY+1)-1:0]         count,
  input  wire logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rd_idx,
  output logic [KEY_W-1:0]                           rd_key,
  output logic [KEY_W-1:0]                           head_key
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [KEY_W-1:0] keys [CAPACITY];
  logic             gts  [CAPACITY];

  // one cell per slot, each wired to its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNT_W-1:0] SLOT = CNT_W'(i);
    logic [KEY_W-1:0] prev_key, next_key;
    logic             prev_gt;

    if (i == 0) begin : g_first
      assign prev_key = '0;
      assign prev_gt = 1'b0;
    end else begin : g_mid
      assign prev_key = keys[i-1];
      assign prev_gt = gts[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_key = keys[i];
    end else begin : g_inner
      assign next_key = keys[i+1];
    end

    ndsk_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .slot_used (SLOT < count),
      .at_count  (SLOT == count),
      .prev_key  (prev_key),
      .prev_gt   (prev_gt),
      .next_key  (next_key),
      .key_o     (keys[i]),
      .gt_o      (gts[i])
    );
  end

  // slot read and oldest key
  assign rd_key = keys[rd_idx];
  assign head_key = keys[0];

endmodule

`default_nettype wire

// File: hdl/newest_dates_sorted_keeper_top.sv
// newest_dates_sorted_keeper_top: request decode, sequencer and result register
// depends on ndsk_pkg, ndsk_name_parser and ndsk_chain
//
// Usage:
//   Input items are taken when start is high and busy is low. An item is a
//   clear (empties the list and restarts the name parser), a name byte
//   (in_last_byte marks the end of a name) or a slot read.
//   Results come one cycle wide on out_strobe; the receiver cannot stall,
//   so every result is taken in the cycle it is shown.
//   Clear, non-final name bytes and read requests leave busy low. A read
//   answer and a malformed-name verdict appear in the cycle after the item.
//   A well-formed name holds busy while the cell row works: the check state
//   gives a drop verdict; otherwise, when the list is full, the evict state
//   drops the oldest keys one at a time (normally one), then the insert
//   state gives the insert verdict. The row shifts or inserts across all
//   cells at once, so each evicted key costs one shift of that row.
//   cfg_we writes max_keep (reset 60); write it only while the block is idle.
//   Reset empties the list, resets the parser and sets max_keep to 60.
`timescale 1ns / 1ps
`default_nettype none

module newest_dates_sorted_keeper_top
  import ndsk_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       in_req_type,
  input  wire logic [7:0]       in_name_byte,
  input  wire logic             in_last_byte,
  input  wire logic [5:0]       in_read_index,
  output logic                  out_strobe,
  output logic                  out_result_kind,
  output logic [1:0]            out_verdict,
  output logic [6:0]            out_held_count,
  output logic [KEY_W-1:0]      out_date_key,
  output logic                  out_slot_valid,
  input  wire logic             cfg_we,
  input  wire logic [6:0]       cfg_wdata
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (CNT_W > 7) ? CNT_W : 7;
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_EVICT,
    S_INSERT
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] count_r;
  logic [KEY_W-1:0] key_r;
  logic [6:0]       max_keep_r;

  logic             accept;
  logic             p_clear, p_byte_en, fin_ok;
  logic [KEY_W-1:0] fin_key, rd_key, head_key;
  chain_ctl_t       ctl;
  logic [CW-1:0]    count_cw, lim_cw, mk_cw, idx_cw, cnt_dec_cw, cnt_inc_cw;
  logic             rd_valid;

  assign busy = (state_r != S_IDLE);
  assign accept = start && !busy;

  // effective keep limit, clamped to 1..CAPACITY
  assign mk_cw = CW'(max_keep_r);
  always_comb begin
    if (mk_cw == '0) begin
      lim_cw = CW'(1);
    end else if (mk_cw > CW'(CAPACITY)) begin
      lim_cw = CW'(CAPACITY);
    end else begin
      lim_cw = mk_cw;
    end
  end

  assign count_cw = CW'(count_r);
  assign cnt_dec_cw = count_cw - CW'(1);
  assign cnt_inc_cw = count_cw + CW'(1);
  assign idx_cw = CW'(in_read_index);
  assign rd_valid = idx_cw < count_cw;

  // name parser
  assign p_clear = accept && (in_req_type == REQ_CLEAR);
  assign p_byte_en = accept && (in_req_type == REQ_NAME);

  ndsk_name_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (p_clear),
    .byte_en   (p_byte_en),
    .name_byte (in_name_byte),
    .last_byte (in_last_byte),
    .fin_ok    (fin_ok),
    .fin_key   (fin_key)
  );

  // cell row control from the sequencer state
  always_comb begin
    ctl.key = key_r;
    case (state_r)
      S_EVICT: ctl.op = OP_SHIFT;
      S_INSERT: ctl.op = OP_INSERT;
      default: ctl.op = OP_HOLD;
    endcase
  end

  ndsk_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk      (clk),
    .ctl      (ctl),
    .count    (count_r),
    .rd_idx   (idx_cw[IDX_W-1:0]),
    .rd_key   (rd_key),
    .head_key (head_key)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_keep_r <= MAX_KEEP_RST;
    end else if (cfg_we) begin
      max_keep_r <= cfg_wdata;
    end
  end

  // sequencer, list count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      key_r <= '0;
      out_strobe <= 1'b0;
      out_result_kind <= KIND_VERDICT;
      out_verdict <= VERD_INSERTED;
      out_held_count <= '0;
      out_date_key <= '0;
      out_slot_valid <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_req_type == REQ_CLEAR) begin
              count_r <= '0;
            end else if (in_req_type == REQ_NAME && in_last_byte) begin
              if (fin_ok) begin
                key_r <= fin_key;
                state_r <= S_CHECK;
              end else begin
                out_strobe <= 1'b1;
                out_result_kind <= KIND_VERDICT;
                out_verdict <= VERD_MALFORMED;
                out_held_count <= count_cw[6:0];
                out_date_key <= '0;
                out_slot_valid <= 1'b0;
              end
            end else if (in_req_type == REQ_READ) begin
              out_strobe <= 1'b1;
              out_result_kind <= KIND_READ;
              out_verdict <= VERD_INSERTED;
              out_held_count <= count_cw[6:0];
              out_date_key <= rd_valid ? rd_key : '0;
              out_slot_valid <= rd_valid;
            end
          end
        end
        S_CHECK: begin
          if (count_cw >= lim_cw) begin
            if (key_r <= head_key) begin
              out_strobe <= 1'b1;
              out_result_kind <= KIND_VERDICT;
              out_verdict <= VERD_DROPPED;
              out_held_count <= count_cw[6:0];
              out_date_key <= '0;
              out_slot_valid <= 1'b0;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_EVICT;
            end
          end else begin
            state_r <= S_INSERT;
          end
        end
        S_EVICT: begin
          // drop the oldest key until limit - 1 remain
          count_r <= cnt_dec_cw[CNT_W-1:0];
          if (count_cw <= lim_cw) begin
            state_r <= S_INSERT;
          end
        end
        S_INSERT: begin
          count_r <= cnt_inc_cw[CNT_W-1:0];
          out_strobe <= 1'b1;
          out_result_kind <= KIND_VERDICT;
          out_verdict <= VERD_INSERTED;
          out_held_count <= cnt_inc_cw[6:0];
          out_date_key <= '0;
          out_slot_valid <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: dv/testbench.sv
// testbench: self-checking bench for newest_dates_sorted_keeper_top
// depends on ndsk_pkg and the top module; keeps its own copy of the date list to predict results
`timescale 1ns / 1ps

module testbench;
  import ndsk_pkg::*;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned NO_CLEAR = 99;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [31:0] CSV_TAIL = ".csv";

  // one result as the block presents it
  typedef struct packed {
    logic kind;
    logic [1:0] verdict;
    logic [6:0] held;
    logic [KEY_W-1:0] key;
    logic valid;
  } answer_t;

  // predicted date list, name parser and the answers still to come
  class date_list_tracker;
    logic [KEY_W-1:0] keys [CAPACITY];
    int unsigned count;
    logic [3:0] pos;
    logic name_good;
    logic [KEY_W-1:0] digits_acc;
    logic [6:0] keep;
    answer_t awaited [$];
    int unsigned errors;

    function new();
      foreach (keys[i]) keys[i] = '0;
      count = 0;
      keep = MAX_KEEP_RST;
      errors = 0;
      restart_name();
    endfunction

    function void restart_name();
      pos = '0;
      name_good = 1'b1;
      digits_acc = '0;
    endfunction

    // advance the prediction by one accepted item
    function void note_item(logic [1:0] req, logic [7:0] b, logic last, logic [5:0] idx);
      answer_t ans;
      int unsigned lim;
      int unsigned drop;
      int unsigned slot;
      ans = '0;
      case (req)
        REQ_CLEAR: begin
          count = 0;
          restart_name();
        end
        REQ_NAME: begin
          // check the byte against its position, fold digits into the key
          if (pos >= NAME_LEN) begin
            name_good = 1'b0;
          end else if (pos == DASH_POS_A || pos == DASH_POS_B) begin
            if (b != CHR_DASH) name_good = 1'b0;
          end else if (pos >= TAIL_POS) begin
            slot = pos - TAIL_POS;
            if (b != CSV_TAIL[8*(3-slot) +: 8]) name_good = 1'b0;
          end else if (b >= CHR_ZERO && b <= CHR_NINE) begin
            digits_acc = digits_acc * 10 + (b - CHR_ZERO);
          end else begin
            name_good = 1'b0;
          end
          if (pos != POS_MAX) pos = pos + 4'd1;
          if (last) begin
            ans.kind = KIND_VERDICT;
            if (!(name_good && pos == NAME_LEN)) begin
              ans.verdict = VERD_MALFORMED;
            end else begin
              lim = keep;
              if (lim < 1) lim = 1;
              if (lim > CAPACITY) lim = CAPACITY;
              ans.verdict = VERD_INSERTED;
              // full list: drop old-or-equal keys, else evict down to lim - 1
              if (count >= lim) begin
                if (digits_acc <= keys[0]) begin
                  ans.verdict = VERD_DROPPED;
                end else begin
                  drop = count - (lim - 1);
                  for (int i = 0; i < count - drop; i++) keys[i] = keys[i + drop];
                  count = count - drop;
                end
              end
              // insert after any equal keys
              if (ans.verdict == VERD_INSERTED) begin
                slot = count;
                while (slot > 0 && keys[slot-1] > digits_acc) begin
                  keys[slot] = keys[slot-1];
                  slot--;
                end
                keys[slot] = digits_acc;
                count++;
              end
            end
            ans.held = count;
            awaited.push_back(ans);
            restart_name();
          end
        end
        REQ_READ: begin
          ans.kind = KIND_READ;
          ans.verdict = VERD_INSERTED;
          ans.held = count;
          if (idx < count) begin
            ans.key = keys[idx];
            ans.valid = 1'b1;
          end
          awaited.push_back(ans);
        end
        default: begin
        end
      endcase
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    // compare one shown result with the oldest awaited answer
    function void check_result(answer_t got);
      answer_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result with none awaited, expected none actual kind %0d key %0d",
                 $time, got.kind, got.key);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare_field("result_kind", want.kind, got.kind);
      compare_field("verdict", want.verdict, got.verdict);
      compare_field("held_count", want.held, got.held);
      compare_field("date_key", want.key, got.key);
      compare_field("slot_valid", want.valid, got.valid);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_req_type;
  logic [7:0] in_name_byte;
  logic in_last_byte;
  logic [5:0] in_read_index;
  logic out_strobe;
  logic out_result_kind;
  logic [1:0] out_verdict;
  logic [6:0] out_held_count;
  logic [KEY_W-1:0] out_date_key;
  logic out_slot_valid;
  logic cfg_we;
  logic [6:0] cfg_wdata;

  date_list_tracker tracker = new();
  logic [7:0] name_buf [$];
  int unsigned items_sent = 0;
  int unsigned cycles = 0;

  newest_dates_sorted_keeper_top #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req_type(in_req_type),
    .in_name_byte(in_name_byte),
    .in_last_byte(in_last_byte),
    .in_read_index(in_read_index),
    .out_strobe(out_strobe),
    .out_result_kind(out_result_kind),
    .out_verdict(out_verdict),
    .out_held_count(out_held_count),
    .out_date_key(out_date_key),
    .out_slot_valid(out_slot_valid),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result monitor and run watchdog
  always @(posedge clk) begin : result_watch
    answer_t seen;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else if (rst_n && out_strobe) begin
      seen = {out_result_kind, out_verdict, out_held_count, out_date_key, out_slot_valid};
      tracker.check_result(seen);
    end
  end

  // present one item, hold it until taken; random idle cycles outside the steady stretch
  task automatic send_item(input logic [1:0] req, input logic [7:0] b, input logic last,
                           input logic [5:0] idx);
    if (items_sent < 300 || items_sent >= 600) begin
      while ($urandom_range(99) < 25) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_req_type <= req;
    in_name_byte <= b;
    in_last_byte <= last;
    in_read_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.note_item(req, b, last, idx);
    items_sent++;
  endtask

  // sender holds off until every awaited answer is in
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (tracker.awaited.size() != 0);
  endtask

  task automatic write_keep(input logic [6:0] value);
    wait_drained();
    repeat (6) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    tracker.keep = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // well-formed YYYY-MM-DD.csv name for the low eight decimal digits of key
  function automatic void build_name(int unsigned key);
    logic [7:0] digit [8];
    int unsigned rest;
    rest = key;
    for (int i = 7; i >= 0; i--) begin
      digit[i] = CHR_ZERO + rest % 10;
      rest = rest / 10;
    end
    name_buf = {};
    for (int i = 0; i < 8; i++) begin
      if (i == 4 || i == 6) name_buf.push_back(CHR_DASH);
      name_buf.push_back(digit[i]);
    end
    for (int i = 3; i >= 0; i--) name_buf.push_back(CSV_TAIL[8*i +: 8]);
  endfunction

  // keys cluster around held ones so drops, ties and evictions happen
  function automatic int unsigned pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (tracker.count > 0 && r < 25) return tracker.keys[$urandom_range(tracker.count - 1)];
    if (tracker.count > 0 && r < 35) return tracker.keys[0] + $urandom_range(1);
    if (r < 40) return ($urandom_range(1) == 1) ? 99999999 : 0;
    if (r < 80) return 20230000 + $urandom_range(1, 3) * 100 + $urandom_range(1, 9);
    return $urandom_range(99999999);
  endfunction

  task automatic send_name(input int unsigned clear_at);
    for (int i = 0; i < name_buf.size(); i++) begin
      if (i == clear_at) send_item(REQ_CLEAR, $urandom_range(255), $urandom_range(1),
                                   $urandom_range(63));
      send_item(REQ_NAME, name_buf[i], i == name_buf.size() - 1, $urandom_range(63));
    end
  endtask

  // one name, well formed or broken in one of several ways
  task automatic name_round(input int unsigned good_pct, input logic clears_ok);
    int unsigned clear_at;
    int unsigned idx;
    clear_at = NO_CLEAR;
    build_name(pick_key());
    if ($urandom_range(99) >= good_pct) begin
      case ($urandom_range(4))
        0: name_buf[$urandom_range(13)] = $urandom_range(255);
        1: begin
          // digit just outside '0'..'9'
          idx = $urandom_range(7);
          idx = idx + (idx >= 4) + (idx >= 6);
          name_buf[idx] = ($urandom_range(1) == 1) ? 8'h2F : 8'h3A;
        end
        2: repeat ($urandom_range(1, 13)) void'(name_buf.pop_back());
        3: repeat ($urandom_range(1, 4)) name_buf.push_back($urandom_range(255));
        default: begin
          if (clears_ok) clear_at = $urandom_range(1, 13);
          else name_buf[$urandom_range(13)] = $urandom_range(255);
        end
      endcase
    end
    send_name(clear_at);
  endtask

  task automatic run_phase(input logic [6:0] keep, input int unsigned names,
                           input int unsigned good_pct, input logic clears_ok);
    int unsigned done;
    int unsigned r;
    logic [5:0] idx;
    write_keep(keep);
    done = 0;
    while (done < names) begin
      r = $urandom_range(99);
      if (r < 12) begin
        idx = ($urandom_range(3) != 0) ? $urandom_range(tracker.count) : $urandom_range(63);
        send_item(REQ_READ, $urandom_range(255), $urandom_range(1), idx);
      end else if (r < 14) begin
        send_item(REQ_UNUSED, $urandom_range(255), $urandom_range(1), $urandom_range(63));
      end else if (r < 17 && clears_ok) begin
        send_item(REQ_CLEAR, $urandom_range(255), $urandom_range(1), $urandom_range(63));
      end else if (r < 19) begin
        wait_drained();
      end else begin
        name_round(good_pct, clears_ok);
        done++;
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_req_type <= REQ_CLEAR;
    in_name_byte <= 8'h00;
    in_last_byte <= 1'b0;
    in_read_index <= 6'd0;
    cfg_we <= 1'b0;
    cfg_wdata <= 7'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty read, highest date, one-byte names, unused request, clear
    send_item(REQ_READ, 8'hFF, 1'b1, 6'd0);
    build_name(99999999);
    send_name(NO_CLEAR);
    send_item(REQ_READ, 8'h00, 1'b0, 6'd0);
    send_item(REQ_NAME, 8'hFF, 1'b1, 6'd63);
    send_item(REQ_NAME, 8'h00, 1'b1, 6'd0);
    send_item(REQ_UNUSED, 8'hFF, 1'b1, 6'd63);
    send_item(REQ_CLEAR, 8'hAA, 1'b1, 6'd21);
    send_item(REQ_READ, 8'h55, 1'b0, 6'd63);

    // random phases: fill past capacity, shrink below held count, then small limits
    run_phase(7'd127, 76, 95, 1'b0);
    run_phase(7'd5, 6, 85, 1'b0);
    run_phase(7'd1, 8, 75, 1'b1);
    run_phase(7'd0, 5, 75, 1'b1);
    run_phase(7'd64, 6, 75, 1'b1);
    run_phase($urandom_range(2, 63), 8, 70, 1'b1);

    wait_drained();
    repeat (80) @(posedge clk);
    if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: newest_dates_sorted_keeper_top.f
hdl/ndsk_pkg.sv
hdl/ndsk_name_parser.sv
hdl/ndsk_cell.sv
hdl/ndsk_chain.sv
hdl/newest_dates_sorted_keeper_top.sv
dv/testbench.sv
